// ===== design/jer_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jer_pkg;

    localparam int KIND_W   = 2;
    localparam int NUM_W    = 8;
    localparam int VALUE_W  = 16;
    localparam int DZ_W     = 15;
    localparam int MAP_W    = 60;
    localparam int MAPH_W   = 20;
    localparam int RAW_W    = 28;
    localparam int GAME_W   = 16;
    localparam int NAV_W    = 4;
    localparam int TGT_W    = 5;
    localparam int CFG_IDX_W = 4;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 48;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AXIS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Axis numbers
    localparam logic [NUM_W-1:0] AXIS_STICK_X = 8'd0;
    localparam logic [NUM_W-1:0] AXIS_STICK_Y = 8'd1;
    localparam logic [NUM_W-1:0] AXIS_L2      = 8'd2;
    localparam logic [NUM_W-1:0] AXIS_R2      = 8'd5;
    localparam logic [NUM_W-1:0] AXIS_DPAD_X  = 8'd6;
    localparam logic [NUM_W-1:0] AXIS_DPAD_Y  = 8'd7;

    localparam logic [NUM_W-1:0] BUTTON_COUNT = 8'd16;

    // Raw bit positions
    localparam int BIT_L2       = 16;
    localparam int BIT_R2       = 17;
    localparam int BIT_DP_UP    = 20;
    localparam int BIT_DP_DOWN  = 21;
    localparam int BIT_DP_LEFT  = 22;
    localparam int BIT_DP_RIGHT = 23;
    localparam int BIT_ST_UP    = 24;
    localparam int BIT_ST_DOWN  = 25;
    localparam int BIT_ST_LEFT  = 26;
    localparam int BIT_ST_RIGHT = 27;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_LOW   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MID   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HIGH  = 4'd3;

    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 15'd10000;
    localparam logic [MAP_W-1:0]  MAP_LOW_RST   = 60'd1134307977866543400;
    localparam logic [MAP_W-1:0]  MAP_MID_RST   = 60'd259138397368483839;
    localparam logic [MAPH_W-1:0] MAP_HIGH_RST  = 20'd235684;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_controls;
        logic [NAV_W-1:0]  nav_directions;
        logic [GAME_W-1:0] game_buttons;
    } result_t;

endpackage

`default_nettype wire

// ===== design/joystick_event_remapper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake                      Payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: number, value; tuser: kind, initial
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: buttons, nav, raw bits
// cfg        in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One event per cycle while the skid slot is empty: the raw-bit update and the
// remap sit between the input handshake and the output register, which holds
// each result. A skid register behind the output register keeps the input open
// for one more beat while the output stalls. Reset clears the raw bits, loads the
// default dead zone and mapping, and empties both output slots.

module joystick_event_remapper (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] control_number, [23:8] event_value
    input  wire logic [jer_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] kind, [2] is_initial
    input  wire logic [jer_pkg::IN_USER_W-1:0]    s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [15:0] game_buttons, [19:16] nav_directions, [47:20] raw_controls
    output logic [jer_pkg::OUT_DATA_W-1:0]        m_axis_tdata,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [jer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [jer_pkg::MAP_W-1:0]        cfg_data
);

    logic [jer_pkg::DZ_W-1:0]   dead_zone_reg;
    logic [jer_pkg::MAP_W-1:0]  map_low_reg;
    logic [jer_pkg::MAP_W-1:0]  map_mid_reg;
    logic [jer_pkg::MAPH_W-1:0] map_high_reg;

    logic [jer_pkg::RAW_W-1:0]  raw_reg;
    logic [jer_pkg::RAW_W-1:0]  raw_next;

    jer_pkg::result_t out_reg;
    jer_pkg::result_t out_next;
    jer_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic [jer_pkg::KIND_W-1:0]  kind;
    logic                        is_initial;
    logic [jer_pkg::NUM_W-1:0]   control_number;
    logic signed [jer_pkg::VALUE_W-1:0] event_value;

    logic signed [jer_pkg::VALUE_W:0] value_ext;
    logic signed [jer_pkg::VALUE_W:0] dz_pos;
    logic signed [jer_pkg::VALUE_W:0] dz_neg;
    logic                             below_dz;
    logic                             above_dz;

    logic [jer_pkg::TGT_W*jer_pkg::RAW_W-1:0] map_all;
    logic [jer_pkg::GAME_W-1:0]               game;
    logic [jer_pkg::TGT_W-1:0]                tgt;

    logic in_fire;
    logic out_fire;

    assign kind           = s_axis_tuser[1:0];
    assign is_initial     = s_axis_tuser[2];
    assign control_number = s_axis_tdata[7:0];
    assign event_value    = s_axis_tdata[23:8];

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // Dead zone compare in 17 bits so -dead_zone never wraps
    assign value_ext = {event_value[jer_pkg::VALUE_W-1], event_value};
    assign dz_pos    = $signed({2'b00, dead_zone_reg});
    assign dz_neg    = -dz_pos;
    assign below_dz  = value_ext < dz_neg;
    assign above_dz  = value_ext > dz_pos;

    always_comb
    begin
        raw_next = raw_reg;
        if (kind == jer_pkg::KIND_CLEAR)
        begin
            raw_next = '0;
        end
        else if (!is_initial && kind == jer_pkg::KIND_BUTTON)
        begin
            if (control_number < jer_pkg::BUTTON_COUNT)
            begin
                raw_next[control_number[3:0]] = (event_value != '0);
            end
        end
        else if (!is_initial && kind == jer_pkg::KIND_AXIS)
        begin
            if (control_number == jer_pkg::AXIS_STICK_X)
            begin
                raw_next[jer_pkg::BIT_ST_LEFT]  = below_dz;
                raw_next[jer_pkg::BIT_ST_RIGHT] = above_dz;
            end
            else if (control_number == jer_pkg::AXIS_STICK_Y)
            begin
                raw_next[jer_pkg::BIT_ST_UP]   = below_dz;
                raw_next[jer_pkg::BIT_ST_DOWN] = above_dz;
            end
            else if (control_number == jer_pkg::AXIS_DPAD_X)
            begin
                raw_next[jer_pkg::BIT_DP_LEFT]  = below_dz;
                raw_next[jer_pkg::BIT_DP_RIGHT] = above_dz;
            end
            else if (control_number == jer_pkg::AXIS_DPAD_Y)
            begin
                raw_next[jer_pkg::BIT_DP_UP]   = below_dz;
                raw_next[jer_pkg::BIT_DP_DOWN] = above_dz;
            end
            else if (control_number == jer_pkg::AXIS_L2)
            begin
                raw_next[jer_pkg::BIT_L2] = (value_ext > 17'sd0);
            end
            else if (control_number == jer_pkg::AXIS_R2)
            begin
                raw_next[jer_pkg::BIT_R2] = (value_ext > 17'sd0);
            end
        end
    end

    // Target of raw bit i sits at bits 5i of the joined map
    assign map_all = {map_high_reg, map_mid_reg, map_low_reg};

    always_comb
    begin
        game = '0;
        tgt  = '0;
        for (int i = 0; i < jer_pkg::RAW_W; i++)
        begin
            tgt = map_all[i*jer_pkg::TGT_W +: jer_pkg::TGT_W];
            // targets with the top bit set are unmapped
            if (raw_next[i] && !tgt[jer_pkg::TGT_W-1])
            begin
                game[tgt[jer_pkg::TGT_W-2:0]] = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_next.game_buttons      = game;
        out_next.nav_directions[0] = raw_next[jer_pkg::BIT_DP_UP]    | raw_next[jer_pkg::BIT_ST_UP];
        out_next.nav_directions[1] = raw_next[jer_pkg::BIT_DP_DOWN]  | raw_next[jer_pkg::BIT_ST_DOWN];
        out_next.nav_directions[2] = raw_next[jer_pkg::BIT_DP_LEFT]  | raw_next[jer_pkg::BIT_ST_LEFT];
        out_next.nav_directions[3] = raw_next[jer_pkg::BIT_DP_RIGHT] | raw_next[jer_pkg::BIT_ST_RIGHT];
        out_next.raw_controls      = raw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= jer_pkg::DEAD_ZONE_RST;
            map_low_reg   <= jer_pkg::MAP_LOW_RST;
            map_mid_reg   <= jer_pkg::MAP_MID_RST;
            map_high_reg  <= jer_pkg::MAP_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                jer_pkg::REG_DEAD_ZONE: dead_zone_reg <= cfg_data[jer_pkg::DZ_W-1:0];
                jer_pkg::REG_MAP_LOW:   map_low_reg   <= cfg_data;
                jer_pkg::REG_MAP_MID:   map_mid_reg   <= cfg_data;
                jer_pkg::REG_MAP_HIGH:  map_high_reg  <= cfg_data[jer_pkg::MAPH_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= '0;
        end
        else if (in_fire)
        begin
            raw_reg <= raw_next;
        end
    end

    // Output register with a skid slot behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            // hold the new beat while the output stalls
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= out_next;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/joystick_event_remapper_test.sv =====
`timescale 1ns / 1ps

module joystick_event_remapper_test;

    localparam logic [jer_pkg::KIND_W-1:0]    KIND_SPARE      = 2'd3;
    localparam logic [jer_pkg::CFG_IDX_W-1:0] REG_FIRST_SPARE = 4'd4;
    localparam logic [jer_pkg::CFG_IDX_W-1:0] REG_LAST_SPARE  = 4'd15;
    localparam int                            CYCLE_LIMIT     = 400000;
    localparam int                            SETTLE_CYCLES   = 4;

    typedef struct {
        logic [jer_pkg::KIND_W-1:0]         kind;
        logic                               is_init;
        logic [jer_pkg::NUM_W-1:0]          num;
        logic signed [jer_pkg::VALUE_W-1:0] value;
    } joy_event_t;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata  = '0;   // [7:0] control_number, [23:8] event_value
    logic [2:0]        s_axis_tuser  = '0;   // [1:0] kind, [2] is_initial
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;         // [15:0] game_buttons, [19:16] nav_directions,
                                             // [47:20] raw_controls
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [3:0]        cfg_index     = '0;
    logic [59:0]       cfg_data      = '0;

    // Shadow copy of the block's state and registers
    logic [jer_pkg::RAW_W-1:0]  raw_bits = '0;
    logic [jer_pkg::DZ_W-1:0]   dz       = jer_pkg::DEAD_ZONE_RST;
    logic [jer_pkg::MAP_W-1:0]  map_lo   = jer_pkg::MAP_LOW_RST;
    logic [jer_pkg::MAP_W-1:0]  map_md   = jer_pkg::MAP_MID_RST;
    logic [jer_pkg::MAPH_W-1:0] map_hi   = jer_pkg::MAP_HIGH_RST;

    jer_pkg::result_t  pending_results[$];
    jer_pkg::result_t  got_beat;
    jer_pkg::result_t  want_beat;
    int                mismatches  = 0;
    int                cycles      = 0;
    bit                tx_idle_on  = 1'b1;
    bit                rx_idle_on  = 1'b1;
    int                rx_hold_len = 0;

    joystick_event_remapper u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic joy_event_t jev(input logic [jer_pkg::KIND_W-1:0] kind,
                                       input logic is_init,
                                       input logic [jer_pkg::NUM_W-1:0] num, input int value);
        joy_event_t ev;
        ev.kind    = kind;
        ev.is_init = is_init;
        ev.num     = num;
        ev.value   = jer_pkg::VALUE_W'(value);
        return ev;
    endfunction

    // One direction pair: at most one side set, symmetric dead zone
    function automatic void steer(input int v, input int neg_bit, input int pos_bit);
        raw_bits[neg_bit] = (v < -int'(dz));
        raw_bits[pos_bit] = (v > int'(dz));
    endfunction

    function automatic jer_pkg::result_t predict_event(input joy_event_t ev);
        jer_pkg::result_t          r;
        int                        v;
        logic [jer_pkg::TGT_W-1:0] tgt;
        v = ev.value;
        case (ev.kind)
            jer_pkg::KIND_CLEAR: raw_bits = '0;
            jer_pkg::KIND_BUTTON:
                if (!ev.is_init && ev.num < jer_pkg::BUTTON_COUNT)
                    raw_bits[ev.num[3:0]] = (ev.value != 0);
            jer_pkg::KIND_AXIS:
                if (!ev.is_init)
                begin
                    case (ev.num)
                        jer_pkg::AXIS_STICK_X:
                            steer(v, jer_pkg::BIT_ST_LEFT, jer_pkg::BIT_ST_RIGHT);
                        jer_pkg::AXIS_STICK_Y:
                            steer(v, jer_pkg::BIT_ST_UP, jer_pkg::BIT_ST_DOWN);
                        jer_pkg::AXIS_DPAD_X:
                            steer(v, jer_pkg::BIT_DP_LEFT, jer_pkg::BIT_DP_RIGHT);
                        jer_pkg::AXIS_DPAD_Y:
                            steer(v, jer_pkg::BIT_DP_UP, jer_pkg::BIT_DP_DOWN);
                        jer_pkg::AXIS_L2: raw_bits[jer_pkg::BIT_L2] = (v > 0);
                        jer_pkg::AXIS_R2: raw_bits[jer_pkg::BIT_R2] = (v > 0);
                        default:          ;
                    endcase
                end
            default: ;
        endcase
        r.game_buttons = '0;
        for (int i = 0; i < jer_pkg::RAW_W; i++)
        begin
            if (i < 12)
                tgt = map_lo[5*i +: jer_pkg::TGT_W];
            else if (i < 24)
                tgt = map_md[5*(i-12) +: jer_pkg::TGT_W];
            else
                tgt = map_hi[5*(i-24) +: jer_pkg::TGT_W];
            if (raw_bits[i] && tgt < jer_pkg::GAME_W)
                r.game_buttons[tgt[3:0]] = 1'b1;
        end
        r.nav_directions = {raw_bits[jer_pkg::BIT_DP_RIGHT] | raw_bits[jer_pkg::BIT_ST_RIGHT],
                            raw_bits[jer_pkg::BIT_DP_LEFT]  | raw_bits[jer_pkg::BIT_ST_LEFT],
                            raw_bits[jer_pkg::BIT_DP_DOWN]  | raw_bits[jer_pkg::BIT_ST_DOWN],
                            raw_bits[jer_pkg::BIT_DP_UP]    | raw_bits[jer_pkg::BIT_ST_UP]};
        r.raw_controls = raw_bits;
        return r;
    endfunction

    // Mostly well-formed button and axis traffic, values clustered at the dead-zone edges
    function automatic joy_event_t random_event();
        joy_event_t ev;
        int         pick;
        int         v;
        ev.kind    = jer_pkg::KIND_BUTTON;
        ev.is_init = ($urandom_range(0, 15) == 0);
        ev.num     = jer_pkg::NUM_W'($urandom);
        ev.value   = jer_pkg::VALUE_W'($urandom);
        pick       = $urandom_range(0, 99);
        if (pick < 45)
        begin
            ev.num = jer_pkg::NUM_W'($urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0)
                ev.value = '0;
        end
        else if (pick < 85)
        begin
            ev.kind = jer_pkg::KIND_AXIS;
            case ($urandom_range(0, 5))
                0:       ev.num = jer_pkg::AXIS_STICK_X;
                1:       ev.num = jer_pkg::AXIS_STICK_Y;
                2:       ev.num = jer_pkg::AXIS_L2;
                3:       ev.num = jer_pkg::AXIS_R2;
                4:       ev.num = jer_pkg::AXIS_DPAD_X;
                default: ev.num = jer_pkg::AXIS_DPAD_Y;
            endcase
            case ($urandom_range(0, 6))
                0:       v = int'(dz);
                1:       v = int'(dz) + 1;
                2:       v = -int'(dz);
                3:       v = -int'(dz) - 1;
                4:       v = 0;
                default: v = ev.value;
            endcase
            if (v > 32767)
                v = 32767;
            ev.value = jer_pkg::VALUE_W'(v);
        end
        else if (pick < 89)
            ev.kind = jer_pkg::KIND_CLEAR;
        else if (pick < 93)
            ev.kind = KIND_SPARE;
        else
            ev.kind = jer_pkg::KIND_W'($urandom_range(0, 1));
        return ev;
    endfunction

    function automatic logic [jer_pkg::MAP_W-1:0] random_map();
        logic [jer_pkg::MAP_W-1:0] m;
        for (int i = 0; i < jer_pkg::MAP_W / jer_pkg::TGT_W; i++)
            m[jer_pkg::TGT_W*i +: jer_pkg::TGT_W] =
                ($urandom_range(0, 3) != 0) ? jer_pkg::TGT_W'($urandom_range(0, 15))
                                            : jer_pkg::TGT_W'($urandom_range(16, 31));
        return m;
    endfunction

    // Present one event, hold it until accepted, then record what it should produce
    task automatic send_event(input joy_event_t ev);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom);
            s_axis_tuser  <= 3'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev.value, ev.num};
        s_axis_tuser  <= {ev.is_init, ev.kind};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_event(ev));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [jer_pkg::CFG_IDX_W-1:0] idx, input logic [59:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            jer_pkg::REG_DEAD_ZONE: dz     = data[jer_pkg::DZ_W-1:0];
            jer_pkg::REG_MAP_LOW:   map_lo = data[jer_pkg::MAP_W-1:0];
            jer_pkg::REG_MAP_MID:   map_md = data[jer_pkg::MAP_W-1:0];
            jer_pkg::REG_MAP_HIGH:  map_hi = data[jer_pkg::MAPH_W-1:0];
            default:                ;
        endcase
    endtask

    task automatic test_directed();
        int d;
        d = int'(jer_pkg::DEAD_ZONE_RST);
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd0, 1));
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd15, -32768));
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd16, 1));
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd255, 32767));
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b1, 8'd0, 0));
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd0, 0));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_X, -32768));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_X, 32767));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_X, d));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_X, -d - 1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_Y, d + 1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_Y, -d));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_DPAD_X, -d - 1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_DPAD_Y, 32767));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_DPAD_Y, -32768));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_L2, 1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_R2, 32767));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_L2, 0));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_R2, -1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, 8'd3, 32767));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, 8'd255, -32768));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b1, jer_pkg::AXIS_DPAD_X, 32767));
        send_event(jev(KIND_SPARE, 1'b0, 8'd1, 1));
        send_event(jev(jer_pkg::KIND_CLEAR, 1'b1, 8'd0, 0));
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd7, 1));
        send_event(jev(jer_pkg::KIND_CLEAR, 1'b0, 8'd255, -1));
    endtask

    task automatic test_dead_zone_edges();
        write_reg(jer_pkg::REG_DEAD_ZONE, '0);
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_X, 1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_Y, -1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_X, 0));
        write_reg(jer_pkg::REG_DEAD_ZONE, 60'(32767));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_DPAD_X, 32767));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_DPAD_Y, -32768));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_DPAD_X, -32767));
        write_reg(jer_pkg::REG_DEAD_ZONE, 60'(jer_pkg::DEAD_ZONE_RST));
    endtask

    task automatic test_map_extremes();
        // everything routed to game button 0
        write_reg(jer_pkg::REG_MAP_LOW, '0);
        write_reg(jer_pkg::REG_MAP_MID, '0);
        write_reg(jer_pkg::REG_MAP_HIGH, '0);
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd9, 1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_STICK_Y, 32767));
        // everything unmapped, upper data bits set beyond the high map register
        write_reg(jer_pkg::REG_MAP_LOW, '1);
        write_reg(jer_pkg::REG_MAP_MID, '1);
        write_reg(jer_pkg::REG_MAP_HIGH, '1);
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd3, 1));
        send_event(jev(jer_pkg::KIND_AXIS, 1'b0, jer_pkg::AXIS_L2, 100));
        write_reg(4'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)), 60'({$urandom, $urandom}));
        write_reg(jer_pkg::REG_MAP_LOW, jer_pkg::MAP_LOW_RST);
        write_reg(jer_pkg::REG_MAP_MID, jer_pkg::MAP_MID_RST);
        write_reg(jer_pkg::REG_MAP_HIGH, 60'(jer_pkg::MAP_HIGH_RST));
        send_event(jev(jer_pkg::KIND_BUTTON, 1'b0, 8'd12, 1));
        send_event(jev(jer_pkg::KIND_CLEAR, 1'b0, 8'd0, 0));
    endtask

    task automatic test_output_stall();
        tx_idle_on  = 1'b0;
        rx_hold_len = 300;
        repeat (40) send_event(random_event());
        tx_idle_on  = 1'b1;
    endtask

    task automatic test_random_phases();
        int dz_val;
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:       dz_val = 0;
                1:       dz_val = 32767;
                default: dz_val = $urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 200);
            endcase
            write_reg(jer_pkg::REG_DEAD_ZONE, 60'(dz_val));
            write_reg(jer_pkg::REG_MAP_LOW, random_map());
            write_reg(jer_pkg::REG_MAP_MID, random_map());
            write_reg(jer_pkg::REG_MAP_HIGH, random_map());
            write_reg(4'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)),
                      60'({$urandom, $urandom}));
            tx_idle_on = (ph < 7);
            rx_idle_on = (ph < 7);
            repeat (170) send_event(random_event());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_dead_zone_edges();
        test_map_extremes();
        test_output_stall();
        test_random_phases();
        drain_results();
        if (mismatches == 0)
            $display("joystick_event_remapper_test passed");
        else
            $display("joystick_event_remapper_test failed");
        $finish;
    end

    // Result side: random stall bursts, plus a long hold-off when one is requested
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_len = 0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_beat = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: expected none, actual %h",
                         $time, got_beat);
                mismatches++;
            end
            else
            begin
                want_beat = pending_results.pop_front();
                compare_field("game_buttons", 32'(want_beat.game_buttons),
                              32'(got_beat.game_buttons));
                compare_field("nav_directions", 32'(want_beat.nav_directions),
                              32'(got_beat.nav_directions));
                compare_field("raw_controls", 32'(want_beat.raw_controls),
                              32'(got_beat.raw_controls));
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("joystick_event_remapper_test failed");
        $finish;
    end

endmodule
